@@ rtl/core/lqm_pkg.sv @@
`timescale 1ns / 1ps

package lqm_pkg;

    // Field widths of the request and response transactions.
    localparam int KIND_W = 2;
    localparam int QID_W  = 2;
    localparam int EID_W  = 6;
    localparam int STAT_W = 2;
    localparam int SIZE_W = 7;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam kind_t KIND_APPEND = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;
    localparam kind_t KIND_SIZE   = 2'd2;

    localparam status_t STAT_OK     = 2'd0;
    localparam status_t STAT_QUEUED = 2'd1;
    localparam status_t STAT_EMPTY  = 2'd2;
    localparam status_t STAT_NOT_IN = 2'd3;

endpackage

@@ rtl/core/lqm_ram.sv @@
`timescale 1ns / 1ps

module lqm_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read, so a stalled operation keeps it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/lqm_info_mem.sv @@
`timescale 1ns / 1ps

module lqm_info_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    output logic          busy
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic          busy_reg;
    logic [AW-1:0] clr_idx_reg;

    // After reset every entry is swept to zero, one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_idx_reg == AW'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

@@ rtl/core/linked_list_queue_manager_unit.sv @@
`timescale 1ns / 1ps
// The request transaction loads the request registers and starts the memory reads.
// The response is registered from state ST_EXEC, or from ST_LINK2 for an append to
// a queue that already holds elements; that state waits while a response is stalled.
// A new request is taken the cycle after the response is registered, so requests
// never overlap; ST_LINK2 is needed since each link memory has a single write port.
// After reset the membership memory is swept entry by entry, stalling requests.

module linked_list_queue_manager_unit #(
    parameter int NUM_ELEMS  = 64,
    parameter int NUM_QUEUES = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [lqm_pkg::KIND_W-1:0]   kind,
    input  logic [lqm_pkg::QID_W-1:0]    queue_id,
    input  logic [lqm_pkg::EID_W-1:0]    elem_id,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [lqm_pkg::STAT_W-1:0]   status,
    output logic [lqm_pkg::SIZE_W-1:0]   size,
    output logic [lqm_pkg::EID_W-1:0]    head_id,
    output logic                         is_empty
);

    import lqm_pkg::*;

    localparam int EW  = $clog2(NUM_ELEMS);
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW  = $clog2(NUM_ELEMS + 1);
    localparam int IW  = QW + 1;
    localparam int EIN = 1 << EID_W;
    localparam int QIN = 1 << QID_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_LINK2 = 2'd2;

    // Reduction tables of the raw element and queue numbers.
    function automatic logic [EIN*EW-1:0] build_elem_map();
        logic [EIN*EW-1:0] r;
        r = '0;
        for (int i = 0; i < EIN; i++)
        begin
            r[i*EW +: EW] = EW'(i % NUM_ELEMS);
        end
        return r;
    endfunction

    function automatic logic [QIN*QW-1:0] build_queue_map();
        logic [QIN*QW-1:0] r;
        r = '0;
        for (int i = 0; i < QIN; i++)
        begin
            r[i*QW +: QW] = QW'(i % NUM_QUEUES);
        end
        return r;
    endfunction

    localparam logic [EIN*EW-1:0] ELEM_MAP  = build_elem_map();
    localparam logic [QIN*QW-1:0] QUEUE_MAP = build_queue_map();

    logic [1:0]          state_reg, state_next;
    kind_t               kind_reg;
    logic [QW-1:0]       q_reg;
    logic [EW-1:0]       e_reg;
    logic [EW-1:0]       hd_reg;
    logic [CW-1:0]       cnt_reg;

    logic [CW-1:0]       cnt_arr [NUM_QUEUES];
    logic [EW-1:0]       head_arr [NUM_QUEUES];

    logic                rsp_valid_reg;
    status_t             status_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [EID_W-1:0]    head_id_reg;
    logic                is_empty_reg;

    logic                req_acc;
    logic                info_busy;
    logic [EW-1:0]       e_in;
    logic [QW-1:0]       q_in;

    logic                next_we, prev_we, info_we;
    logic [EW-1:0]       next_wa, prev_wa, info_wa;
    logic [EW-1:0]       next_wd, prev_wd;
    logic [IW-1:0]       info_wd;
    logic [EW-1:0]       prev_ra;
    logic [EW-1:0]       nx_rd, pv_rd;
    logic [IW-1:0]       info_rd;

    logic                cnt_we, head_we;
    logic [CW-1:0]       cnt_wd;
    logic [EW-1:0]       head_wd;

    logic                res_load;
    status_t             res_status;
    logic [CW-1:0]       res_cnt;
    logic [EW-1:0]       res_head;

    logic                go;
    logic                inf_v;
    logic [QW-1:0]       inf_own;
    logic                cnt_zero, cnt_one;

    assign e_in = ELEM_MAP[elem_id*EW +: EW];
    assign q_in = QUEUE_MAP[queue_id*QW +: QW];

    assign req_stall = (state_reg != ST_IDLE) || info_busy;
    assign req_acc   = req_valid && !req_stall;

    // Append reads the tail through the head's prev link; remove reads the element's.
    assign prev_ra = (kind == KIND_APPEND) ? head_arr[q_in] : e_in;

    lqm_ram #(.DEPTH(NUM_ELEMS), .AW(EW), .DW(EW)) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_en   (req_acc),
        .rd_addr (e_in),
        .rd_data (nx_rd)
    );

    lqm_ram #(.DEPTH(NUM_ELEMS), .AW(EW), .DW(EW)) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_wa),
        .wr_data (prev_wd),
        .rd_en   (req_acc),
        .rd_addr (prev_ra),
        .rd_data (pv_rd)
    );

    lqm_info_mem #(.DEPTH(NUM_ELEMS), .AW(EW), .DW(IW)) u_info_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (info_we),
        .wr_addr (info_wa),
        .wr_data (info_wd),
        .rd_en   (req_acc),
        .rd_addr (e_in),
        .rd_data (info_rd),
        .busy    (info_busy)
    );

    assign inf_v    = info_rd[IW-1];
    assign inf_own  = info_rd[QW-1:0];
    assign cnt_zero = (cnt_reg == '0);
    assign cnt_one  = (cnt_reg == CW'(1));
    assign go       = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        next_we    = 1'b0;
        next_wa    = e_reg;
        next_wd    = e_reg;
        prev_we    = 1'b0;
        prev_wa    = e_reg;
        prev_wd    = e_reg;
        info_we    = 1'b0;
        info_wa    = e_reg;
        info_wd    = {1'b1, q_reg};
        cnt_we     = 1'b0;
        cnt_wd     = cnt_reg;
        head_we    = 1'b0;
        head_wd    = e_reg;
        res_load   = 1'b0;
        res_status = STAT_OK;
        res_cnt    = cnt_reg;
        res_head   = hd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (kind_reg == KIND_APPEND && !inf_v && !cnt_zero)
                begin
                    // Link the old tail to the new element and the head back to it.
                    next_we    = 1'b1;
                    next_wa    = pv_rd;
                    next_wd    = e_reg;
                    prev_we    = 1'b1;
                    prev_wa    = hd_reg;
                    prev_wd    = e_reg;
                    info_we    = 1'b1;
                    cnt_we     = 1'b1;
                    cnt_wd     = cnt_reg + 1'b1;
                    state_next = ST_LINK2;
                end
                else if (go)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (kind_reg)
                        KIND_APPEND:
                        begin
                            if (inf_v)
                            begin
                                res_status = STAT_QUEUED;
                            end
                            else
                            begin
                                next_we  = 1'b1;
                                prev_we  = 1'b1;
                                info_we  = 1'b1;
                                cnt_we   = 1'b1;
                                cnt_wd   = cnt_reg + 1'b1;
                                head_we  = 1'b1;
                                res_cnt  = cnt_reg + 1'b1;
                                res_head = e_reg;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (cnt_zero)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else if (!inf_v || inf_own != q_reg)
                            begin
                                res_status = STAT_NOT_IN;
                            end
                            else
                            begin
                                info_we = 1'b1;
                                info_wd = {1'b0, q_reg};
                                cnt_we  = 1'b1;
                                cnt_wd  = cnt_reg - 1'b1;
                                res_cnt = cnt_reg - 1'b1;
                                if (!cnt_one)
                                begin
                                    next_we = 1'b1;
                                    next_wa = pv_rd;
                                    next_wd = nx_rd;
                                    prev_we = 1'b1;
                                    prev_wa = nx_rd;
                                    prev_wd = pv_rd;
                                    if (hd_reg == e_reg)
                                    begin
                                        head_we  = 1'b1;
                                        head_wd  = nx_rd;
                                        res_head = nx_rd;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            res_status = STAT_OK;
                        end
                    endcase
                end
            end

            ST_LINK2:
            begin
                if (go)
                begin
                    // Close the ring: the new element points to the head and the old tail.
                    next_we    = 1'b1;
                    next_wd    = hd_reg;
                    prev_we    = 1'b1;
                    prev_wd    = pv_rd;
                    res_load   = 1'b1;
                    res_cnt    = cnt_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            kind_reg <= kind;
            q_reg    <= q_in;
            e_reg    <= e_in;
            hd_reg   <= head_arr[q_in];
            cnt_reg  <= cnt_arr[q_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                cnt_arr[i] <= '0;
            end
        end
        else if (cnt_we)
        begin
            cnt_arr[q_reg] <= cnt_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_arr[q_reg] <= head_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg   <= res_status;
            size_reg     <= SIZE_W'(res_cnt);
            head_id_reg  <= (res_cnt == '0) ? '0 : EID_W'(res_head);
            is_empty_reg <= (res_cnt == '0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign size      = size_reg;
    assign head_id   = head_id_reg;
    assign is_empty  = is_empty_reg;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import lqm_pkg::*;

    localparam int NUM_ELEMS  = 64;
    localparam int NUM_QUEUES = 4;

    // The unused kind code is answered like a size query.
    localparam kind_t KIND_SPARE = 2'd3;

    typedef struct packed {
        status_t           status;
        logic [SIZE_W-1:0] size;
        logic [EID_W-1:0]  head_id;
        logic              is_empty;
    } rsp_t;

    class queue_tracker;
        logic [EID_W-1:0]  link_next [NUM_ELEMS];
        logic [EID_W-1:0]  link_prev [NUM_ELEMS];
        bit                member    [NUM_ELEMS];
        logic [QID_W-1:0]  owner     [NUM_ELEMS];
        logic [EID_W-1:0]  head      [NUM_QUEUES];
        logic [SIZE_W-1:0] count     [NUM_QUEUES];
        rsp_t              expected_rsp [$];
        int                errors;
        int                checked;
        int                peak_size;

        function new();
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                link_next[i] = '0;
                link_prev[i] = '0;
                member[i]    = 1'b0;
                owner[i]     = '0;
            end
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head[i]  = '0;
                count[i] = '0;
            end
            errors    = 0;
            checked   = 0;
            peak_size = 0;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        // Picks a random queued element of queue q, or a random free element when
        // want_member is clear. Returns -1 when there is none.
        function int pick_elem(bit want_member, logic [QID_W-1:0] q);
            int found [$];
            for (int i = 0; i < NUM_ELEMS; i++)
                if (want_member ? (member[i] && owner[i] == q) : !member[i])
                    found.push_back(i);
            if (found.size() == 0)
                return -1;
            return found[$urandom_range(0, found.size() - 1)];
        endfunction

        function rsp_t predict(kind_t k, logic [QID_W-1:0] q, logic [EID_W-1:0] e);
            rsp_t             r;
            logic [EID_W-1:0] h;
            logic [EID_W-1:0] t;
            logic [EID_W-1:0] n;
            logic [EID_W-1:0] p;
            r.status = STAT_OK;
            if (k == KIND_APPEND)
            begin
                if (member[e])
                    r.status = STAT_QUEUED;
                else
                begin
                    if (count[q] == 0)
                    begin
                        head[q]      = e;
                        link_next[e] = e;
                        link_prev[e] = e;
                    end
                    else
                    begin
                        h            = head[q];
                        t            = link_prev[h];
                        link_next[t] = e;
                        link_prev[e] = t;
                        link_next[e] = h;
                        link_prev[h] = e;
                    end
                    member[e] = 1'b1;
                    owner[e]  = q;
                    count[q]  = count[q] + 1'b1;
                end
            end
            else if (k == KIND_REMOVE)
            begin
                // The empty check wins over the membership check.
                if (count[q] == 0)
                    r.status = STAT_EMPTY;
                else if (!member[e] || owner[e] != q)
                    r.status = STAT_NOT_IN;
                else
                begin
                    if (count[q] == 1)
                        head[q] = '0;
                    else
                    begin
                        n = link_next[e];
                        p = link_prev[e];
                        if (head[q] == e)
                            head[q] = n;
                        link_next[p] = n;
                        link_prev[n] = p;
                    end
                    member[e] = 1'b0;
                    count[q]  = count[q] - 1'b1;
                end
            end
            r.size     = count[q];
            r.head_id  = (count[q] != 0) ? head[q] : '0;
            r.is_empty = (count[q] == 0);
            return r;
        endfunction

        function void note_request(kind_t k, logic [QID_W-1:0] q, logic [EID_W-1:0] e);
            expected_rsp.push_back(predict(k, q, e));
        endfunction

        function void compare_field(string name, logic [7:0] expv, logic [7:0] actv);
            if (actv !== expv)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
                errors++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: response with no request outstanding, status %0d size %0d",
                         $time, got.status, got.size);
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("size", 8'(want.size), 8'(got.size));
            compare_field("head_id", 8'(want.head_id), 8'(got.head_id));
            compare_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
            checked++;
            if (int'(got.size) > peak_size)
                peak_size = int'(got.size);
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    kind_t             kind      = KIND_SIZE;
    logic [QID_W-1:0]  queue_id  = '0;
    logic [EID_W-1:0]  elem_id   = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] size;
    logic [EID_W-1:0]  head_id;
    logic              is_empty;

    queue_tracker book = new();
    bit           send_calm = 1'b0;
    bit           recv_calm = 1'b0;
    int           sent      = 0;

    linked_list_queue_manager_unit #(
        .NUM_ELEMS  (NUM_ELEMS),
        .NUM_QUEUES (NUM_QUEUES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .queue_id  (queue_id),
        .elem_id   (elem_id),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .size      (size),
        .head_id   (head_id),
        .is_empty  (is_empty)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Returns at the clock edge where the request transaction is taken.
    task automatic send_request(kind_t k, logic [QID_W-1:0] q, logic [EID_W-1:0] e);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        queue_id  <= q;
        elem_id   <= e;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        book.note_request(k, q, e);
        sent++;
    endtask

    // Mostly well-formed traffic: appends of free elements, removals of elements
    // that really sit in the addressed queue, and size queries. The fill flavor piles
    // elements into queue 2 so that it grows close to the whole pool.
    task automatic random_request(bit fill);
        kind_t            k;
        logic [QID_W-1:0] q;
        logic [EID_W-1:0] e;
        int               roll;
        int               pick;
        roll = $urandom_range(0, 99);
        q    = QID_W'($urandom_range(0, NUM_QUEUES - 1));
        e    = EID_W'($urandom_range(0, NUM_ELEMS - 1));
        if (fill)
        begin
            if (roll < 85)
            begin
                k    = KIND_APPEND;
                q    = 2'd2;
                pick = book.pick_elem(1'b0, q);
                if (pick >= 0 && roll < 75)
                    e = EID_W'(pick);
            end
            else
            begin
                k = KIND_REMOVE;
                q = QID_W'($urandom_range(0, 2));
                if (q == 2'd2)
                    q = 2'd3;
                pick = book.pick_elem(1'b1, q);
                if (pick >= 0)
                    e = EID_W'(pick);
            end
        end
        else if (roll < 40)
        begin
            k    = KIND_APPEND;
            pick = book.pick_elem(1'b0, q);
            if (pick >= 0 && $urandom_range(0, 9) < 6)
                e = EID_W'(pick);
        end
        else if (roll < 80)
        begin
            k    = KIND_REMOVE;
            pick = book.pick_elem(1'b1, q);
            if (pick >= 0 && $urandom_range(0, 3) != 0)
                e = EID_W'(pick);
        end
        else if (roll < 95)
            k = KIND_SIZE;
        else
            k = KIND_SPARE;
        send_request(k, q, e);
    endtask

    // Response side: unless recv_calm is set, may hold stall for a random spell before
    // each transaction, then waits for the transaction to happen.
    initial
    begin : rsp_side
        int hold;
        forever
        begin
            hold = recv_calm ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            book.check_response({status, size, head_id, is_empty});
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_request(KIND_SIZE, 2'd0, 6'd0);
        send_request(KIND_SPARE, 2'd3, 6'd63);
        send_request(KIND_REMOVE, 2'd1, 6'd5);
        send_request(KIND_APPEND, 2'd0, 6'd0);
        send_request(KIND_APPEND, 2'd0, 6'd63);
        send_request(KIND_APPEND, 2'd0, 6'd10);
        send_request(KIND_APPEND, 2'd1, 6'd63);
        send_request(KIND_APPEND, 2'd0, 6'd0);
        send_request(KIND_REMOVE, 2'd1, 6'd10);
        send_request(KIND_APPEND, 2'd1, 6'd20);
        send_request(KIND_REMOVE, 2'd1, 6'd10);
        send_request(KIND_REMOVE, 2'd1, 6'd33);
        send_request(KIND_REMOVE, 2'd0, 6'd63);
        send_request(KIND_REMOVE, 2'd0, 6'd0);
        send_request(KIND_SIZE, 2'd0, 6'd0);
        send_request(KIND_REMOVE, 2'd0, 6'd10);
        send_request(KIND_APPEND, 2'd3, 6'd42);
        send_request(KIND_APPEND, 2'd3, 6'd21);
        send_request(KIND_REMOVE, 2'd3, 6'd21);
        send_request(KIND_REMOVE, 2'd3, 6'd42);
        send_request(KIND_SIZE, 2'd3, 6'd0);
        send_request(KIND_REMOVE, 2'd1, 6'd20);
        send_request(KIND_SIZE, 2'd2, 6'd63);

        // Let the block drain completely before the random traffic starts.
        req_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);

        repeat (200) random_request(1'b0);
        send_calm = 1'b1;
        recv_calm = 1'b1;
        repeat (150) random_request(1'b1);
        recv_calm = 1'b0;
        repeat (100) random_request(1'b0);
        send_calm = 1'b0;
        recv_calm = 1'b1;
        repeat (80) random_request(1'b0);
        recv_calm = 1'b0;

        req_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests and checked %0d responses, %0d mismatches.",
                 sent, book.checked, book.errors);
        $display("Largest queue size seen in a response: %0d.", book.peak_size);
        if (book.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin : watchdog
        #400000;
        $display("Timeout with %0d responses outstanding.", book.pending());
        $display("tb failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/lqm_pkg.sv
rtl/core/lqm_ram.sv
rtl/core/lqm_info_mem.sv
rtl/core/linked_list_queue_manager_unit.sv
verif/tb.sv
